// ===== design/acfb_pkg.sv =====
`default_nettype none

package acfb_pkg;

    typedef enum logic [3:0] {
        OP_SET_SCRATCH  = 4'd0,
        OP_READ_SCRATCH = 4'd1,
        OP_FIXED_SEQ    = 4'd2,
        OP_POINTING     = 4'd3,
        OP_ARRAY_CFG    = 4'd4,
        OP_FACTORY_RST  = 4'd5,
        OP_ENABLE_BEAM  = 4'd6,
        OP_STATUS_SUM   = 4'd7,
        OP_STATUS_DET   = 4'd8
    } t_opcode;

    localparam int unsigned MAX_FRAME = 9;

    localparam logic [7:0] HDR_SET_SCRATCH  = 8'h81;
    localparam logic [7:0] HDR_READ_SCRATCH = 8'h82;
    localparam logic [7:0] HDR_FIXED_SEQ    = 8'h83;
    localparam logic [7:0] HDR_POINTING     = 8'hA0;
    localparam logic [7:0] HDR_ARRAY_CFG    = 8'hB1;
    localparam logic [7:0] HDR_FACTORY_RST  = 8'hC0;
    localparam logic [7:0] HDR_ENABLE_BEAM  = 8'hE0;
    localparam logic [7:0] HDR_STATUS_SUM   = 8'hF0;
    localparam logic [7:0] HDR_STATUS_DET   = 8'hF1;
    localparam logic [7:0] RST_KEY_HI       = 8'hBA;
    localparam logic [7:0] RST_KEY_LO       = 8'h11;

    localparam logic [3:0] REPLY_DEFAULT    = 4'd6;
    localparam logic [3:0] REPLY_ARRAY_CFG  = 4'd10;
    localparam logic [3:0] REPLY_STATUS_SUM = 4'd3;
    localparam logic [3:0] REPLY_STATUS_DET = 4'd14;

    localparam logic [15:0] CODE_MAX = 16'hFFFF;

    // floor(y / 45) = (y * DIV45_MUL) >> DIV45_SHIFT, exact for y < 2^22
    localparam int unsigned DIV_IN_W    = 22;
    localparam int unsigned DIV45_SHIFT = 28;
    localparam logic [22:0] DIV45_MUL   = 23'd5965233;
    localparam int unsigned PROD_W      = 45;
    localparam int unsigned QUOT_W      = 17;

    typedef struct packed {
        t_opcode     op;
        logic [31:0] scratch;
        logic [2:0]  mode_byte;
        logic [15:0] freq;
        logic        rst_confirm;
        logic        beam_on;
    } t_cmd;

    typedef struct packed {
        logic [MAX_FRAME-1:0][7:0] frame_bytes;
        logic [3:0]                frame_len;
        logic [3:0]                reply_len;
    } t_frame;

endpackage

`default_nettype wire

// ===== design/acfb_front.sv =====
`default_nettype none

module acfb_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [3:0]            i_opcode,
    input  wire logic [31:0]           i_scratch_value,
    input  wire logic                  i_transmit,
    input  wire logic [1:0]            i_beam_mode,
    input  wire logic [14:0]           i_theta_angle,
    input  wire logic [16:0]           i_phi_angle,
    input  wire logic [15:0]           i_freq_mhz,
    input  wire logic                  i_reset_confirm,
    input  wire logic                  i_beam_on,
    output logic                       o_push,
    output acfb_pkg::t_frame           o_frame,
    input  wire logic                  i_q_ready
);

    logic                               r_s1_valid;
    acfb_pkg::t_cmd                     r_s1_cmd;
    logic [acfb_pkg::DIV_IN_W-1:0]      r_s1_ty;
    logic [acfb_pkg::DIV_IN_W-1:0]      r_s1_py;
    logic                               r_s2_valid;
    acfb_pkg::t_cmd                     r_s2_cmd;
    logic [acfb_pkg::QUOT_W-1:0]        r_s2_tq;
    logic [acfb_pkg::QUOT_W-1:0]        r_s2_pq;

    logic [30:0]                        w_tx;
    logic [32:0]                        w_px;
    logic [acfb_pkg::PROD_W-1:0]        w_tprod;
    logic [acfb_pkg::PROD_W-1:0]        w_pprod;
    logic [15:0]                        w_tcode;
    logic [15:0]                        w_pcode;
    logic                               w_has_frame;
    logic                               w_adv;
    logic [7:0]                         w_csum;
    acfb_pkg::t_frame                   w_frame;

    // angle * 65535, then the power-of-two part of the span is shifted off
    assign w_tx = {i_theta_angle, 16'h0000} - 31'(i_theta_angle);
    assign w_px = {i_phi_angle, 16'h0000} - 33'(i_phi_angle);

    assign w_tprod = acfb_pkg::PROD_W'(r_s1_ty) * acfb_pkg::PROD_W'(acfb_pkg::DIV45_MUL);
    assign w_pprod = acfb_pkg::PROD_W'(r_s1_py) * acfb_pkg::PROD_W'(acfb_pkg::DIV45_MUL);

    assign w_tcode = r_s2_tq[16] ? acfb_pkg::CODE_MAX : r_s2_tq[15:0];
    assign w_pcode = r_s2_pq[16] ? acfb_pkg::CODE_MAX : r_s2_pq[15:0];

    assign w_adv   = !r_s2_valid || !w_has_frame || i_q_ready;
    assign o_ready = w_adv;
    assign o_push  = r_s2_valid && w_has_frame && i_q_ready;
    assign o_frame = w_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_cmd.op          <= acfb_pkg::t_opcode'(i_opcode);
            r_s1_cmd.scratch     <= i_scratch_value;
            r_s1_cmd.mode_byte   <= {i_transmit, i_beam_mode};
            r_s1_cmd.freq        <= i_freq_mhz;
            r_s1_cmd.rst_confirm <= i_reset_confirm;
            r_s1_cmd.beam_on     <= i_beam_on;
            r_s1_ty              <= w_tx[30:9];
            r_s1_py              <= w_px[32:11];
            r_s2_cmd             <= r_s1_cmd;
            r_s2_tq              <= w_tprod[acfb_pkg::PROD_W-1:acfb_pkg::DIV45_SHIFT];
            r_s2_pq              <= w_pprod[acfb_pkg::PROD_W-1:acfb_pkg::DIV45_SHIFT];
        end
    end

    always_comb begin
        w_frame             = '0;
        w_frame.reply_len   = acfb_pkg::REPLY_DEFAULT;
        w_has_frame         = 1'b1;
        w_csum              = '0;
        case (r_s2_cmd.op)
            acfb_pkg::OP_SET_SCRATCH: begin
                w_frame.frame_bytes[0] = acfb_pkg::HDR_SET_SCRATCH;
                w_frame.frame_bytes[1] = r_s2_cmd.scratch[31:24];
                w_frame.frame_bytes[2] = r_s2_cmd.scratch[23:16];
                w_frame.frame_bytes[3] = r_s2_cmd.scratch[15:8];
                w_frame.frame_bytes[4] = r_s2_cmd.scratch[7:0];
                w_frame.frame_len      = 4'd6;
            end
            acfb_pkg::OP_READ_SCRATCH: begin
                w_frame.frame_bytes[0] = acfb_pkg::HDR_READ_SCRATCH;
                w_frame.frame_len      = 4'd2;
            end
            acfb_pkg::OP_FIXED_SEQ: begin
                w_frame.frame_bytes[0] = acfb_pkg::HDR_FIXED_SEQ;
                w_frame.frame_len      = 4'd2;
            end
            acfb_pkg::OP_POINTING: begin
                w_frame.frame_bytes[0] = acfb_pkg::HDR_POINTING;
                w_frame.frame_bytes[1] = {5'b00000, r_s2_cmd.mode_byte};
                w_frame.frame_bytes[2] = w_tcode[15:8];
                w_frame.frame_bytes[3] = w_tcode[7:0];
                w_frame.frame_bytes[4] = w_pcode[15:8];
                w_frame.frame_bytes[5] = w_pcode[7:0];
                w_frame.frame_bytes[6] = r_s2_cmd.freq[15:8];
                w_frame.frame_bytes[7] = r_s2_cmd.freq[7:0];
                w_frame.frame_len      = 4'd9;
            end
            acfb_pkg::OP_ARRAY_CFG: begin
                w_frame.frame_bytes[0] = acfb_pkg::HDR_ARRAY_CFG;
                w_frame.frame_len      = 4'd2;
                w_frame.reply_len      = acfb_pkg::REPLY_ARRAY_CFG;
            end
            acfb_pkg::OP_FACTORY_RST: begin
                w_frame.frame_bytes[0] = acfb_pkg::HDR_FACTORY_RST;
                w_frame.frame_bytes[1] = r_s2_cmd.rst_confirm ? acfb_pkg::RST_KEY_HI : 8'h00;
                w_frame.frame_bytes[2] = r_s2_cmd.rst_confirm ? acfb_pkg::RST_KEY_LO : 8'h00;
                w_frame.frame_len      = 4'd4;
            end
            acfb_pkg::OP_ENABLE_BEAM: begin
                w_frame.frame_bytes[0] = acfb_pkg::HDR_ENABLE_BEAM;
                w_frame.frame_bytes[1] = {7'b0000000, r_s2_cmd.beam_on};
                w_frame.frame_len      = 4'd3;
            end
            acfb_pkg::OP_STATUS_SUM: begin
                w_frame.frame_bytes[0] = acfb_pkg::HDR_STATUS_SUM;
                w_frame.frame_len      = 4'd2;
                w_frame.reply_len      = acfb_pkg::REPLY_STATUS_SUM;
            end
            acfb_pkg::OP_STATUS_DET: begin
                w_frame.frame_bytes[0] = acfb_pkg::HDR_STATUS_DET;
                w_frame.frame_len      = 4'd2;
                w_frame.reply_len      = acfb_pkg::REPLY_STATUS_DET;
            end
            default: begin
                w_has_frame = 1'b0;
            end
        endcase
        // unused bytes are zero, so xor over all payload slots is the checksum
        for (int i = 0; i < acfb_pkg::MAX_FRAME - 1; i++) begin
            w_csum = w_csum ^ w_frame.frame_bytes[i];
        end
        for (int i = 1; i < acfb_pkg::MAX_FRAME; i++) begin
            if (w_frame.frame_len == 4'(i + 1)) begin
                w_frame.frame_bytes[i] = w_csum;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/acfb_queue.sv =====
`default_nettype none

module acfb_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire acfb_pkg::t_frame   i_frame,
    output logic                    o_ready,
    output logic                    o_valid,
    output acfb_pkg::t_frame        o_head,
    input  wire logic               i_pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    acfb_pkg::t_frame   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wp;
    logic [PTR_W-1:0]   r_rp;
    logic [CNT_W-1:0]   r_cnt;
    logic [PTR_W-1:0]   n_wp;
    logic [PTR_W-1:0]   n_rp;

    assign o_ready = r_cnt != CNT_W'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_head  = r_mem[r_rp];

    assign n_wp = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign n_rp = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= n_wp;
            end
            if (i_pop) begin
                r_rp <= n_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_frame;
        end
    end

endmodule

`default_nettype wire

// ===== design/acfb_back.sv =====
`default_nettype none

module acfb_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  wire acfb_pkg::t_frame   i_head,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [7:0]              o_frame_byte,
    output logic [3:0]              o_reply_length,
    output logic                    o_last_byte
);

    logic [3:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic [3:0] r_reply;
    logic       r_last;
    logic       w_load;
    logic       w_last;

    assign w_load = i_q_valid && (!r_valid || i_ready);
    assign w_last = r_idx == (i_head.frame_len - 4'd1);
    assign o_pop  = w_load && w_last;

    assign o_valid        = r_valid;
    assign o_frame_byte   = r_byte;
    assign o_reply_length = r_reply;
    assign o_last_byte    = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= w_last ? 4'd0 : r_idx + 4'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte  <= i_head.frame_bytes[r_idx];
            r_reply <= i_head.reply_len;
            r_last  <= w_last;
        end
    end

endmodule

`default_nettype wire

// ===== design/antenna_command_frame_builder_top.sv =====
// Path: a command item passes two front stages (span scaling, then reciprocal
// multiply), then the queue, then the output byte register of the back end.
// Throughput: one frame byte per cycle while i_out_ready is high; a frame holds
// 2..9 bytes, and the front takes one item per cycle until the queue fills.
// Reset: synchronous active-low i_rst_n clears stage valids, queue pointers and
// the output valid; no clearing pass, block is ready the cycle after reset.
`default_nettype none

module antenna_command_frame_builder_top #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire logic [3:0]     i_opcode,
    input  wire logic [31:0]    i_scratch_value,
    input  wire logic           i_transmit,
    input  wire logic [1:0]     i_beam_mode,
    input  wire logic [14:0]    i_theta_angle,
    input  wire logic [16:0]    i_phi_angle,
    input  wire logic [15:0]    i_freq_mhz,
    input  wire logic           i_reset_confirm,
    input  wire logic           i_beam_on,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic [7:0]          o_frame_byte,
    output logic [3:0]          o_reply_length,
    output logic                o_last_byte
);

    logic               w_push;
    logic               w_q_ready;
    logic               w_q_valid;
    logic               w_pop;
    acfb_pkg::t_frame   w_frame;
    acfb_pkg::t_frame   w_head;

    acfb_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .o_ready         (o_in_ready),
        .i_opcode        (i_opcode),
        .i_scratch_value (i_scratch_value),
        .i_transmit      (i_transmit),
        .i_beam_mode     (i_beam_mode),
        .i_theta_angle   (i_theta_angle),
        .i_phi_angle     (i_phi_angle),
        .i_freq_mhz      (i_freq_mhz),
        .i_reset_confirm (i_reset_confirm),
        .i_beam_on       (i_beam_on),
        .o_push          (w_push),
        .o_frame         (w_frame),
        .i_q_ready       (w_q_ready)
    );

    acfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_frame (w_frame),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    acfb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_frame_byte   (o_frame_byte),
        .o_reply_length (o_reply_length),
        .o_last_byte    (o_last_byte)
    );

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_q_ready)
        else $error("frame pushed into full queue");

    a_pop_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("frame popped from empty queue");

    a_reply_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_reply_length == acfb_pkg::REPLY_DEFAULT ||
                         o_reply_length == acfb_pkg::REPLY_ARRAY_CFG ||
                         o_reply_length == acfb_pkg::REPLY_STATUS_SUM ||
                         o_reply_length == acfb_pkg::REPLY_STATUS_DET))
        else $error("illegal reply length on output");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !w_q_valid)
        else $error("output or queue not empty after reset");

endmodule

`default_nettype wire

// ===== dv/antenna_command_frame_builder_top_tb.sv =====
module antenna_command_frame_builder_top_tb;

    localparam int unsigned THETA_SPAN    = 23040;
    localparam int unsigned PHI_SPAN      = 92160;
    localparam int unsigned STALL_LIMIT   = 3000;
    localparam int unsigned DRAIN_PAD     = 12;
    localparam int unsigned SINK_HOLD_LEN = 150;
    localparam int unsigned REPORT_MAX    = 10;

    // opcodes past the status detail command produce no frame
    localparam logic [3:0] OP_NONE_FIRST = 4'd9;
    localparam logic [3:0] OP_NONE_LAST  = 4'd15;

    typedef struct {
        logic [3:0]  op;
        logic [31:0] scratch;
        logic        tx;
        logic [1:0]  mode;
        logic [14:0] theta;
        logic [16:0] phi;
        logic [15:0] freq;
        logic        rst_ok;
        logic        on;
    } t_cmd_req;

    typedef struct {
        logic [7:0] fbyte;
        logic [3:0] reply;
        logic       last_flag;
    } t_frame_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [3:0]  i_opcode;
    logic [31:0] i_scratch_value;
    logic        i_transmit;
    logic [1:0]  i_beam_mode;
    logic [14:0] i_theta_angle;
    logic [16:0] i_phi_angle;
    logic [15:0] i_freq_mhz;
    logic        i_reset_confirm;
    logic        i_beam_on;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_frame_byte;
    logic [3:0]  o_reply_length;
    logic        o_last_byte;

    t_frame_byte frame_q[$];
    int          mismatches;
    int unsigned idle_cycles;
    bit          steady;
    int unsigned sink_hold;

    antenna_command_frame_builder_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_scratch_value (i_scratch_value),
        .i_transmit      (i_transmit),
        .i_beam_mode     (i_beam_mode),
        .i_theta_angle   (i_theta_angle),
        .i_phi_angle     (i_phi_angle),
        .i_freq_mhz      (i_freq_mhz),
        .i_reset_confirm (i_reset_confirm),
        .i_beam_on       (i_beam_on),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_frame_byte    (o_frame_byte),
        .o_reply_length  (o_reply_length),
        .o_last_byte     (o_last_byte)
    );

    always #5 i_clk = ~i_clk;

    function automatic void flag_error(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("%s", msg);
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(12, 40);
    endfunction

    // floor scaling of a 1/256 degree angle onto 0..65535, saturating
    function automatic logic [15:0] angle_to_code(input logic [16:0] angle,
                                                  input int unsigned span);
        longint unsigned q;
        q = angle;
        q = (q * acfb_pkg::CODE_MAX) / span;
        if (q > acfb_pkg::CODE_MAX) begin
            q = acfb_pkg::CODE_MAX;
        end
        return q[15:0];
    endfunction

    function automatic void predict_frame(input t_cmd_req c);
        logic [7:0]  fb[$];
        logic [3:0]  rlen;
        logic [15:0] tc;
        logic [15:0] pc;
        logic [7:0]  sum;
        t_frame_byte e;
        rlen = acfb_pkg::REPLY_DEFAULT;
        case (c.op)
            acfb_pkg::OP_SET_SCRATCH: begin
                fb = '{acfb_pkg::HDR_SET_SCRATCH, c.scratch[31:24], c.scratch[23:16],
                       c.scratch[15:8], c.scratch[7:0]};
            end
            acfb_pkg::OP_READ_SCRATCH: fb = '{acfb_pkg::HDR_READ_SCRATCH};
            acfb_pkg::OP_FIXED_SEQ:    fb = '{acfb_pkg::HDR_FIXED_SEQ};
            acfb_pkg::OP_POINTING: begin
                tc = angle_to_code({2'b00, c.theta}, THETA_SPAN);
                pc = angle_to_code(c.phi, PHI_SPAN);
                fb = '{acfb_pkg::HDR_POINTING, {5'd0, c.tx, c.mode}, tc[15:8], tc[7:0],
                       pc[15:8], pc[7:0], c.freq[15:8], c.freq[7:0]};
            end
            acfb_pkg::OP_ARRAY_CFG: begin
                fb = '{acfb_pkg::HDR_ARRAY_CFG};
                rlen = acfb_pkg::REPLY_ARRAY_CFG;
            end
            acfb_pkg::OP_FACTORY_RST: begin
                fb = '{acfb_pkg::HDR_FACTORY_RST,
                       c.rst_ok ? acfb_pkg::RST_KEY_HI : 8'h00,
                       c.rst_ok ? acfb_pkg::RST_KEY_LO : 8'h00};
            end
            acfb_pkg::OP_ENABLE_BEAM: fb = '{acfb_pkg::HDR_ENABLE_BEAM, {7'd0, c.on}};
            acfb_pkg::OP_STATUS_SUM: begin
                fb = '{acfb_pkg::HDR_STATUS_SUM};
                rlen = acfb_pkg::REPLY_STATUS_SUM;
            end
            acfb_pkg::OP_STATUS_DET: begin
                fb = '{acfb_pkg::HDR_STATUS_DET};
                rlen = acfb_pkg::REPLY_STATUS_DET;
            end
            default: return;
        endcase
        sum = 8'h00;
        foreach (fb[i]) begin
            sum ^= fb[i];
        end
        fb.push_back(sum);
        foreach (fb[i]) begin
            e.fbyte     = fb[i];
            e.reply     = rlen;
            e.last_flag = (i == fb.size() - 1);
            frame_q.push_back(e);
        end
    endfunction

    function automatic t_cmd_req rand_cmd();
        t_cmd_req    c;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            c.op = 4'($urandom_range(OP_NONE_FIRST, OP_NONE_LAST));
        end else if (r < 35) begin
            c.op = acfb_pkg::OP_POINTING;
        end else begin
            c.op = 4'($urandom_range(acfb_pkg::OP_SET_SCRATCH, acfb_pkg::OP_STATUS_DET));
        end
        c.scratch = $urandom();
        c.tx      = 1'($urandom_range(0, 1));
        c.mode    = 2'($urandom_range(0, 3));
        // mostly in range, sometimes the full field to reach saturation
        c.theta   = ($urandom_range(0, 7) == 0) ? 15'($urandom())
                                                : 15'($urandom_range(0, THETA_SPAN));
        c.phi     = ($urandom_range(0, 7) == 0) ? 17'($urandom())
                                                : 17'($urandom_range(0, PHI_SPAN));
        c.freq    = 16'($urandom());
        c.rst_ok  = 1'($urandom_range(0, 1));
        c.on      = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // valid is only lowered by a gap or by park_source, never right before a raise
    task automatic send_cmd(input t_cmd_req c);
        int unsigned gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid      <= 1'b1;
        i_opcode        <= c.op;
        i_scratch_value <= c.scratch;
        i_transmit      <= c.tx;
        i_beam_mode     <= c.mode;
        i_theta_angle   <= c.theta;
        i_phi_angle     <= c.phi;
        i_freq_mhz      <= c.freq;
        i_reset_confirm <= c.rst_ok;
        i_beam_on       <= c.on;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        predict_frame(c);
    endtask

    task automatic park_source();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // pad covers items with unused opcodes still in the front stages
    task automatic wait_drained();
        while (frame_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic test_directed();
        t_cmd_req c;
        c = rand_cmd();
        c.op = acfb_pkg::OP_SET_SCRATCH;
        c.scratch = 32'h0000_0000;          send_cmd(c);
        c.scratch = 32'hFFFF_FFFF;          send_cmd(c);
        c.scratch = 32'hA55A_3CC3;          send_cmd(c);
        c.op = acfb_pkg::OP_READ_SCRATCH;   send_cmd(c);
        c.op = acfb_pkg::OP_FIXED_SEQ;      send_cmd(c);
        c.op = acfb_pkg::OP_POINTING;
        c.tx = 1'b0; c.mode = 2'd0;
        c.theta = '0; c.phi = '0; c.freq = 16'h0000;
        send_cmd(c);
        c.tx = 1'b1; c.mode = 2'd3;
        c.theta = 15'(THETA_SPAN); c.phi = 17'(PHI_SPAN); c.freq = 16'hFFFF;
        send_cmd(c);
        // angles past full scale saturate
        c.tx = 1'b1; c.mode = 2'd1;
        c.theta = 15'h7FFF; c.phi = 17'h1FFFF;
        send_cmd(c);
        c.theta = 15'(THETA_SPAN + 1); c.phi = 17'(PHI_SPAN + 1);
        send_cmd(c);
        c.tx = 1'b0; c.mode = 2'd2;
        c.theta = 15'd1; c.phi = 17'd1; c.freq = 16'h1234;
        send_cmd(c);
        c.theta = 15'(THETA_SPAN - 1); c.phi = 17'(PHI_SPAN - 1);
        send_cmd(c);
        c.op = acfb_pkg::OP_ARRAY_CFG;      send_cmd(c);
        c.op = acfb_pkg::OP_FACTORY_RST;
        c.rst_ok = 1'b0;                    send_cmd(c);
        c.rst_ok = 1'b1;                    send_cmd(c);
        c.op = acfb_pkg::OP_ENABLE_BEAM;
        c.on = 1'b0;                        send_cmd(c);
        c.on = 1'b1;                        send_cmd(c);
        c.op = acfb_pkg::OP_STATUS_SUM;     send_cmd(c);
        c.op = acfb_pkg::OP_STATUS_DET;     send_cmd(c);
        // no frame for these; followed by a real command to see nothing slipped in
        c.op = OP_NONE_FIRST;               send_cmd(c);
        c.op = OP_NONE_LAST;                send_cmd(c);
        c.op = acfb_pkg::OP_READ_SCRATCH;   send_cmd(c);
    endtask

    task automatic test_random_mix();
        repeat (220) send_cmd(rand_cmd());
    endtask

    // sink stalls long while commands keep coming, so the queue fills
    task automatic test_backpressure();
        t_cmd_req c;
        steady    = 1'b1;
        sink_hold = SINK_HOLD_LEN;
        repeat (16) begin
            c = rand_cmd();
            if ($urandom_range(0, 1) == 1) begin
                c.op = acfb_pkg::OP_POINTING;
            end
            send_cmd(c);
        end
        steady = 1'b0;
    endtask

    task automatic test_drain_pause();
        repeat (2) begin
            repeat (10) send_cmd(rand_cmd());
            park_source();
            wait_drained();
        end
    endtask

    task automatic test_steady_stream();
        steady = 1'b1;
        repeat (40) send_cmd(rand_cmd());
        steady = 1'b0;
    endtask

    always begin
        int unsigned stall;
        @(negedge i_clk);
        if (sink_hold != 0) begin
            i_out_ready <= 1'b0;
            repeat (sink_hold) @(negedge i_clk);
            sink_hold = 0;
            i_out_ready <= 1'b1;
        end else if (!steady && $urandom_range(0, 99) < 30) begin
            stall = pick_gap() + 1;
            i_out_ready <= 1'b0;
            repeat (stall) @(negedge i_clk);
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_frame_byte e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (frame_q.size() == 0) begin
                flag_error($sformatf("unexpected item: byte=%h reply=%0d last=%b",
                                     o_frame_byte, o_reply_length, o_last_byte));
            end else begin
                e = frame_q.pop_front();
                if (o_frame_byte !== e.fbyte || o_reply_length !== e.reply ||
                    o_last_byte !== e.last_flag) begin
                    flag_error($sformatf(
                        "mismatch: exp byte=%h reply=%0d last=%b got byte=%h reply=%0d last=%b",
                        e.fbyte, e.reply, e.last_flag,
                        o_frame_byte, o_reply_length, o_last_byte));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_out_ready     = 1'b0;
        i_opcode        = acfb_pkg::OP_SET_SCRATCH;
        i_scratch_value = '0;
        i_transmit      = 1'b0;
        i_beam_mode     = '0;
        i_theta_angle   = '0;
        i_phi_angle     = '0;
        i_freq_mhz      = '0;
        i_reset_confirm = 1'b0;
        i_beam_on       = 1'b0;
        mismatches      = 0;
        idle_cycles     = 0;
        steady          = 1'b0;
        sink_hold       = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_mix();
        test_backpressure();
        test_drain_pause();
        test_steady_stream();

        park_source();
        wait_drained();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== antenna_command_frame_builder_top.f =====
design/acfb_pkg.sv
design/acfb_front.sv
design/acfb_queue.sv
design/acfb_back.sv
design/antenna_command_frame_builder_top.sv
dv/antenna_command_frame_builder_top_tb.sv
